### rtl/brf_pkg.sv
// shared types and constants of the banked register file
package brf_pkg;

	localparam logic [4:0] MODE_USR  = 5'h10;
	localparam logic [4:0] MODE_FAST = 5'h11;
	localparam logic [4:0] MODE_INTR = 5'h12;
	localparam logic [4:0] MODE_SVC  = 5'h13;
	localparam logic [4:0] MODE_ABT  = 5'h17;
	localparam logic [4:0] MODE_UND  = 5'h1B;
	localparam logic [4:0] MODE_SYS  = 5'h1F;

	localparam logic [31:0] RESET_SP_USR = 32'h0300_7F00;
	localparam logic [31:0] RESET_SP_IRQ = 32'h0300_7FA0;
	localparam logic [31:0] RESET_SP_SVC = 32'h0300_7FE0;
	localparam logic [31:0] RESET_PC     = 32'h0800_0000;

	localparam logic [3:0] REG_FIQ_FIRST = 4'd8;
	localparam logic [3:0] REG_SP        = 4'd13;
	localparam logic [3:0] REG_LR        = 4'd14;
	localparam logic [3:0] REG_PC        = 4'd15;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [3:0] {
		COND_EQ = 4'd0,
		COND_NE = 4'd1,
		COND_CS = 4'd2,
		COND_CC = 4'd3,
		COND_MI = 4'd4,
		COND_PL = 4'd5,
		COND_VS = 4'd6,
		COND_VC = 4'd7,
		COND_HI = 4'd8,
		COND_LS = 4'd9,
		COND_GE = 4'd10,
		COND_LT = 4'd11,
		COND_GT = 4'd12,
		COND_LE = 4'd13,
		COND_AL = 4'd14,
		COND_NV = 4'd15
	} cond_code_t;

	typedef enum logic [2:0] {
		OP_READ_REG    = 3'd0,
		OP_WRITE_REG   = 3'd1,
		OP_READ_SAVED  = 3'd2,
		OP_WRITE_SAVED = 3'd3,
		OP_CHANGE_MODE = 3'd4,
		OP_SET_FLAG    = 3'd5,
		OP_TEST_COND   = 3'd6,
		OP_NONE        = 3'd7
	} brf_op_t;

	typedef struct packed {
		brf_op_t     op;
		logic        banked_op;
		logic        use_current;
		logic [3:0]  reg_index;
		logic [4:0]  bank_mode;
		logic [31:0] write_value;
		logic [3:0]  condition;
		logic [1:0]  flag_select;
		logic        flag_value;
	} brf_item_t;

endpackage

### rtl/brf_front.sv
// front end: accepts input beats and classifies them into queue items
module brf_front import brf_pkg::*; (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [3:0]  reg_index,
	input  logic [4:0]  bank_mode,
	input  logic [31:0] write_value,
	input  logic [3:0]  condition,
	input  logic [1:0]  flag_select,
	input  logic        flag_value,
	input  logic        queue_full,
	output logic        push,
	output brf_item_t   item
);

	brf_op_t op;

	always_comb begin
		case (mode)
			OP_READ_REG:    op = OP_READ_REG;
			OP_WRITE_REG:   op = OP_WRITE_REG;
			OP_READ_SAVED:  op = OP_READ_SAVED;
			OP_WRITE_SAVED: op = OP_WRITE_SAVED;
			OP_CHANGE_MODE: op = OP_CHANGE_MODE;
			OP_SET_FLAG:    op = OP_SET_FLAG;
			OP_TEST_COND:   op = OP_TEST_COND;
			default: op = OP_NONE;
		endcase
	end

	always_comb begin
		item.op          = op;
		item.banked_op   = (op == OP_READ_REG) || (op == OP_WRITE_REG) ||
			(op == OP_READ_SAVED) || (op == OP_WRITE_SAVED) || (op == OP_CHANGE_MODE);
		item.use_current = (bank_mode == 5'd0);
		item.reg_index   = reg_index;
		item.bank_mode   = bank_mode;
		item.write_value = write_value;
		item.condition   = condition;
		item.flag_select = flag_select;
		item.flag_value  = flag_value;
	end

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

endmodule

### rtl/brf_queue.sv
// short queue of classified items between front and back
module brf_queue import brf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  brf_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output brf_item_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	brf_item_t          entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### rtl/brf_back.sv
// back end: banked registers, status word, mode change and condition test
module brf_back import brf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  brf_item_t   item,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_value,
	output logic        cond_passed,
	output logic        bad_mode,
	output logic        privileged
);

	logic [31:0] low_regs_q [13];
	logic [31:0] fiq_high_q [5];
	logic [31:0] sp_lr_q    [12];
	logic [31:0] pc_q;
	logic [31:0] status_q;
	logic [31:0] saved_q    [5];
	logic [4:0]  cur_mode_q;

	logic        out_valid_q;
	logic [31:0] read_value_q;
	logic        cond_passed_q;
	logic        bad_mode_q;
	logic        privileged_q;

	logic [4:0]  eff;
	logic        bank_ok;
	logic [2:0]  bank;
	logic        bad;
	logic        is_low;
	logic        is_fiq_high;
	logic        is_pc;
	logic [3:0]  sp_idx;
	logic [2:0]  saved_idx;
	logic [31:0] reg_rd;
	logic [31:0] status_rd;
	logic [31:0] rd;
	logic        pass;
	logic [4:0]  next_mode;
	logic        do_mode;

	function automatic logic cond_holds(input logic [3:0] c, input logic n,
		input logic z, input logic cf, input logic v);
		logic res;
		case (c)
			COND_EQ: res = z;
			COND_NE: res = !z;
			COND_CS: res = cf;
			COND_CC: res = !cf;
			COND_MI: res = n;
			COND_PL: res = !n;
			COND_VS: res = v;
			COND_VC: res = !v;
			COND_HI: res = cf && !z;
			COND_LS: res = !cf || z;
			COND_GE: res = (n == v);
			COND_LT: res = (n != v);
			COND_GT: res = !z && (n == v);
			COND_LE: res = z || (n != v);
			COND_AL: res = 1'b1;
			default: res = 1'b0;
		endcase
		return res;
	endfunction

	assign pop = item_valid && (!out_valid_q || !out_stall);

	always_comb begin
		eff = item.use_current ? cur_mode_q : item.bank_mode;
		bank_ok = 1'b1;
		case (eff)
			MODE_USR, MODE_SYS: bank = 3'd0;
			MODE_FAST:          bank = 3'd1;
			MODE_INTR:          bank = 3'd2;
			MODE_SVC:           bank = 3'd3;
			MODE_ABT:           bank = 3'd4;
			MODE_UND:           bank = 3'd5;
			default: begin
				bank    = 3'd0;
				bank_ok = 1'b0;
			end
		endcase
		bad         = item.banked_op && !bank_ok;
		is_low      = (item.reg_index < REG_SP);
		is_fiq_high = is_low && (item.reg_index >= REG_FIQ_FIRST) && (eff == MODE_FAST);
		is_pc       = (item.reg_index == REG_PC);
		sp_idx      = {bank, item.reg_index == REG_LR};
		saved_idx   = bank - 3'd1;

		if (is_fiq_high) begin
			reg_rd = fiq_high_q[item.reg_index[2:0]];
		end else if (is_low) begin
			reg_rd = low_regs_q[item.reg_index];
		end else if (is_pc) begin
			reg_rd = pc_q;
		end else if (bank_ok) begin
			reg_rd = sp_lr_q[sp_idx];
		end else begin
			reg_rd = '0;
		end

		if (!bank_ok) begin
			status_rd = '0;
		end else if (bank == 3'd0) begin
			status_rd = status_q;
		end else begin
			status_rd = saved_q[saved_idx];
		end

		case (item.op)
			OP_READ_REG:   rd = reg_rd;
			OP_READ_SAVED: rd = status_rd;
			default:       rd = '0;
		endcase

		pass = (item.op == OP_TEST_COND) &&
			cond_holds(item.condition, status_q[31], status_q[30], status_q[29], status_q[28]);

		do_mode   = (item.op == OP_CHANGE_MODE) && bank_ok;
		next_mode = do_mode ? eff : cur_mode_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 13; i++) begin
				low_regs_q[i] <= '0;
			end
			for (int i = 0; i < 5; i++) begin
				fiq_high_q[i] <= '0;
				saved_q[i]    <= '0;
			end
			for (int i = 0; i < 12; i++) begin
				sp_lr_q[i] <= '0;
			end
			sp_lr_q[0] <= RESET_SP_USR;
			sp_lr_q[4] <= RESET_SP_IRQ;
			sp_lr_q[6] <= RESET_SP_SVC;
			pc_q       <= RESET_PC;
			status_q   <= {27'd0, MODE_SYS};
			cur_mode_q <= MODE_SYS;
		end else if (pop) begin
			case (item.op)
				OP_WRITE_REG: begin
					if (is_fiq_high) begin
						fiq_high_q[item.reg_index[2:0]] <= item.write_value;
					end else if (is_low) begin
						low_regs_q[item.reg_index] <= item.write_value;
					end else if (is_pc) begin
						pc_q <= item.write_value;
					end else if (bank_ok) begin
						sp_lr_q[sp_idx] <= item.write_value;
					end
				end
				OP_WRITE_SAVED: begin
					if (bank_ok) begin
						if (bank == 3'd0) begin
							status_q <= item.write_value;
						end else begin
							saved_q[saved_idx] <= item.write_value;
						end
					end
				end
				OP_CHANGE_MODE: begin
					if (do_mode) begin
						cur_mode_q    <= eff;
						status_q[4:0] <= eff;
					end
				end
				OP_SET_FLAG: begin
					status_q[5'd28 + 5'(item.flag_select)] <= item.flag_value;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			read_value_q  <= rd;
			cond_passed_q <= pass;
			bad_mode_q    <= bad;
			privileged_q  <= (next_mode != MODE_USR);
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign cond_passed = cond_passed_q;
	assign bad_mode    = bad_mode_q;
	assign privileged  = privileged_q;

endmodule

### rtl/banked_register_file_with_conditions.sv
// top level of the banked register file with condition test
//
//  channel | handshake            | beat fields
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | mode reg_index bank_mode write_value
//          |                      | condition flag_select flag_value
//  out     | out_valid / out_stall| read_value cond_passed bad_mode privileged
//
// one beat per cycle sustained while out_stall is low; a result beat passes
// through a queue entry and then the output register
// the back end executes one queued item per cycle into its output register unless out_stall holds it
// reset sets the register file, status word and mode to their architectural reset values at once
// out_stall holds the output register; the two-entry queue then fills and
// raises in_stall
module banked_register_file_with_conditions import brf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [3:0]  reg_index,
	input  logic [4:0]  bank_mode,
	input  logic [31:0] write_value,
	input  logic [3:0]  condition,
	input  logic [1:0]  flag_select,
	input  logic        flag_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_value,
	output logic        cond_passed,
	output logic        bad_mode,
	output logic        privileged
);

	logic      push;
	logic      queue_full;
	logic      queue_not_empty;
	logic      pop;
	brf_item_t front_item;
	brf_item_t head_item;

	brf_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.reg_index   (reg_index),
		.bank_mode   (bank_mode),
		.write_value (write_value),
		.condition   (condition),
		.flag_select (flag_select),
		.flag_value  (flag_value),
		.queue_full  (queue_full),
		.push        (push),
		.item        (front_item)
	);

	brf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (queue_not_empty),
		.head      (head_item)
	);

	brf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (queue_not_empty),
		.item        (head_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_value  (read_value),
		.cond_passed (cond_passed),
		.bad_mode    (bad_mode),
		.privileged  (privileged)
	);

endmodule
